/* sv/srp_pkg.sv */
// Shared types and constants for the SNMP response parser.
// Used by the front parser, the command queue and the result emitter.
`default_nettype none

package srp_pkg;

    // Result kinds as they appear on the result channel.
    localparam logic [3:0] KIND_VERSION = 4'd0;
    localparam logic [3:0] KIND_REQ_ID  = 4'd1;
    localparam logic [3:0] KIND_STATUS  = 4'd2;
    localparam logic [3:0] KIND_ERR_IDX = 4'd3;
    localparam logic [3:0] KIND_OID_ARC = 4'd4;
    localparam logic [3:0] KIND_SIGNED  = 4'd5;
    localparam logic [3:0] KIND_UNSIGN  = 4'd6;
    localparam logic [3:0] KIND_STR     = 4'd7;
    localparam logic [3:0] KIND_BARE    = 4'd8;
    localparam logic [3:0] KIND_FAIL    = 4'd9;

    // One command from the parser to the emitter. A split command carries
    // the first OID octet and expands into two arc results.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  arc;
        logic [7:0]  vtype;
        logic        last;
        logic        split;
    } srp_cmd_t;

endpackage

`default_nettype wire

/* sv/srp_front.sv */
// Front part of the SNMP response parser: walks the BER structure one octet per
// cycle while the queue has room, pushing result commands. Depends on srp_pkg.
`default_nettype none

module srp_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_data_byte,
    input  wire logic            s_start_req,
    input  wire logic            q_full,
    output logic                 q_push,
    output srp_pkg::srp_cmd_t    q_cmd
);
    import srp_pkg::*;

    localparam logic [7:0] TAG_SEQ  = 8'h30;
    localparam logic [7:0] TAG_INT  = 8'h02;
    localparam logic [7:0] TAG_OCT  = 8'h04;
    localparam logic [7:0] TAG_OID  = 8'h06;
    localparam logic [7:0] TAG_CNT  = 8'h41;
    localparam logic [7:0] TAG_GAU  = 8'h42;
    localparam logic [7:0] TAG_RESP = 8'hA2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TOP_TAG, ST_TOP_LEN, ST_VER_TAG, ST_VER_LEN, ST_VER_VAL,
        ST_COM_TAG, ST_COM_LEN, ST_COM_SKIP, ST_PDU_TAG, ST_PDU_LEN,
        ST_RID_TAG, ST_RID_LEN, ST_RID_VAL, ST_STA_TAG, ST_STA_LEN,
        ST_STA_VAL, ST_EIX_TAG, ST_EIX_LEN, ST_EIX_VAL, ST_VBL_TAG,
        ST_VBL_LEN, ST_VB_TAG, ST_VB_LEN, ST_OID_TAG, ST_OID_LEN,
        ST_OID_FIRST, ST_OID_ARC, ST_VAL_TAG, ST_VAL_LEN, ST_VAL_INT,
        ST_VAL_STR
    } stage_t;

    stage_t      stage_reg, stage_next, stage_cur;
    logic [7:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  arcs_reg, arcs_next;
    logic [7:0]  vtag_reg, vtag_next;
    logic        first_reg, first_next;

    logic        accept;
    logic        int_tag;
    logic [31:0] int_base;
    logic [31:0] int_acc;
    logic [31:0] arc_acc;
    logic [7:0]  left_dec;
    logic        value_kind_signed;

    // The queue alone decides whether an octet can be taken.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // A start octet restarts parsing from the message tag.
    assign stage_cur = s_start_req ? ST_TOP_TAG : stage_reg;

    assign int_tag  = (s_data_byte == TAG_INT) || (s_data_byte == TAG_CNT) ||
                      (s_data_byte == TAG_GAU);
    assign int_base = (first_reg && s_data_byte[7]) ? 32'hFFFF_FFFF : acc_reg;
    assign int_acc  = {int_base[23:0], s_data_byte};
    assign arc_acc  = {acc_reg[24:0], s_data_byte[6:0]};
    assign left_dec = left_reg - 8'd1;
    assign value_kind_signed = (vtag_reg == TAG_INT);

    // Stage decoder: next state and the command this octet produces.
    always_comb begin
        stage_next = stage_cur;
        left_next  = left_reg;
        acc_next   = acc_reg;
        arcs_next  = arcs_reg;
        vtag_next  = vtag_reg;
        first_next = first_reg;
        q_push     = 1'b0;
        q_cmd      = '0;

        unique case (stage_cur)
            ST_IDLE: begin
            end
            ST_TOP_TAG: begin
                if (s_data_byte == TAG_SEQ) begin
                    stage_next = ST_TOP_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_TOP_LEN: stage_next = ST_VER_TAG;
            ST_VER_TAG: begin
                if (int_tag) begin
                    stage_next = ST_VER_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_VER_LEN, ST_RID_LEN: begin
                left_next  = s_data_byte;
                acc_next   = '0;
                first_next = 1'b1;
                if (s_data_byte == 8'd0) begin
                    q_push     = 1'b1;
                    q_cmd.kind = (stage_cur == ST_VER_LEN) ? KIND_VERSION : KIND_REQ_ID;
                    stage_next = (stage_cur == ST_VER_LEN) ? ST_COM_TAG : ST_STA_TAG;
                end else begin
                    stage_next = (stage_cur == ST_VER_LEN) ? ST_VER_VAL : ST_RID_VAL;
                end
            end
            ST_VER_VAL, ST_RID_VAL: begin
                acc_next   = int_acc;
                first_next = 1'b0;
                left_next  = left_dec;
                if (left_dec == 8'd0) begin
                    q_push      = 1'b1;
                    q_cmd.kind  = (stage_cur == ST_VER_VAL) ? KIND_VERSION : KIND_REQ_ID;
                    q_cmd.value = int_acc;
                    stage_next  = (stage_cur == ST_VER_VAL) ? ST_COM_TAG : ST_STA_TAG;
                end
            end
            ST_COM_TAG: begin
                if (s_data_byte == TAG_OCT) begin
                    stage_next = ST_COM_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_COM_LEN: begin
                left_next  = s_data_byte;
                stage_next = (s_data_byte == 8'd0) ? ST_PDU_TAG : ST_COM_SKIP;
            end
            ST_COM_SKIP: begin
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    stage_next = ST_PDU_TAG;
                end
            end
            ST_PDU_TAG: begin
                if (s_data_byte == TAG_RESP) begin
                    stage_next = ST_PDU_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_PDU_LEN: stage_next = ST_RID_TAG;
            ST_RID_TAG: begin
                if (int_tag) begin
                    stage_next = ST_RID_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_STA_TAG, ST_EIX_TAG: begin
                if (s_data_byte == TAG_INT) begin
                    stage_next = (stage_cur == ST_STA_TAG) ? ST_STA_LEN : ST_EIX_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_STA_LEN, ST_EIX_LEN: begin
                if (s_data_byte == 8'd1) begin
                    stage_next = (stage_cur == ST_STA_LEN) ? ST_STA_VAL : ST_EIX_VAL;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_STA_VAL, ST_EIX_VAL: begin
                q_push      = 1'b1;
                q_cmd.kind  = (stage_cur == ST_STA_VAL) ? KIND_STATUS : KIND_ERR_IDX;
                q_cmd.value = {24'd0, s_data_byte};
                stage_next  = (stage_cur == ST_STA_VAL) ? ST_EIX_TAG : ST_VBL_TAG;
            end
            ST_VBL_TAG, ST_VB_TAG: begin
                if (s_data_byte == TAG_SEQ) begin
                    stage_next = (stage_cur == ST_VBL_TAG) ? ST_VBL_LEN : ST_VB_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_VBL_LEN: stage_next = ST_VB_TAG;
            ST_VB_LEN:  stage_next = ST_OID_TAG;
            ST_OID_TAG: begin
                if (s_data_byte == TAG_OID) begin
                    stage_next = ST_OID_LEN;
                end else begin
                    q_push = 1'b1;
                end
            end
            ST_OID_LEN: begin
                left_next  = s_data_byte;
                arcs_next  = '0;
                acc_next   = '0;
                stage_next = (s_data_byte == 8'd0) ? ST_VAL_TAG : ST_OID_FIRST;
            end
            ST_OID_FIRST: begin
                // The emitter splits this octet into the first two arcs.
                q_push      = 1'b1;
                q_cmd.kind  = KIND_OID_ARC;
                q_cmd.value = {24'd0, s_data_byte};
                q_cmd.split = 1'b1;
                arcs_next   = 8'd2;
                acc_next    = '0;
                left_next   = left_dec;
                stage_next  = (left_dec == 8'd0) ? ST_VAL_TAG : ST_OID_ARC;
            end
            ST_OID_ARC: begin
                acc_next  = arc_acc;
                left_next = left_dec;
                if (!s_data_byte[7] || (left_dec == 8'd0)) begin
                    q_push      = 1'b1;
                    q_cmd.kind  = KIND_OID_ARC;
                    q_cmd.value = arc_acc;
                    q_cmd.arc   = arcs_reg;
                    arcs_next   = arcs_reg + 8'd1;
                    acc_next    = '0;
                end
                if (left_dec == 8'd0) begin
                    stage_next = ST_VAL_TAG;
                end
            end
            ST_VAL_TAG: begin
                vtag_next = s_data_byte;
                if (int_tag || (s_data_byte == TAG_OCT)) begin
                    stage_next = ST_VAL_LEN;
                end else begin
                    q_push      = 1'b1;
                    q_cmd.kind  = KIND_BARE;
                    q_cmd.vtype = s_data_byte;
                    q_cmd.last  = 1'b1;
                    stage_next  = ST_IDLE;
                end
            end
            ST_VAL_LEN: begin
                left_next = s_data_byte;
                if (vtag_reg != TAG_OCT) begin
                    acc_next   = '0;
                    first_next = 1'b1;
                end
                if (s_data_byte == 8'd0) begin
                    // Empty value: bare type for a string, zero for an integer.
                    q_push      = 1'b1;
                    q_cmd.vtype = vtag_reg;
                    q_cmd.last  = 1'b1;
                    if (vtag_reg == TAG_OCT) begin
                        q_cmd.kind = KIND_BARE;
                    end else begin
                        q_cmd.kind = value_kind_signed ? KIND_SIGNED : KIND_UNSIGN;
                    end
                    stage_next = ST_IDLE;
                end else begin
                    stage_next = (vtag_reg == TAG_OCT) ? ST_VAL_STR : ST_VAL_INT;
                end
            end
            ST_VAL_INT: begin
                acc_next   = int_acc;
                first_next = 1'b0;
                left_next  = left_dec;
                if (left_dec == 8'd0) begin
                    q_push      = 1'b1;
                    q_cmd.kind  = value_kind_signed ? KIND_SIGNED : KIND_UNSIGN;
                    q_cmd.value = int_acc;
                    q_cmd.vtype = vtag_reg;
                    q_cmd.last  = 1'b1;
                    stage_next  = ST_IDLE;
                end
            end
            ST_VAL_STR: begin
                left_next   = left_dec;
                q_push      = 1'b1;
                q_cmd.kind  = KIND_STR;
                q_cmd.value = {24'd0, s_data_byte};
                q_cmd.vtype = vtag_reg;
                q_cmd.last  = (left_dec == 8'd0);
                if (left_dec == 8'd0) begin
                    stage_next = ST_IDLE;
                end
            end
        endcase

        // Any failure emits one final result and parks the parser.
        if (q_push && (q_cmd.kind == KIND_VERSION) && (stage_next == stage_cur)) begin
            q_cmd.kind = KIND_FAIL;
            q_cmd.last = 1'b1;
            stage_next = ST_IDLE;
        end

        // Only an accepted octet may produce a command.
        if (!accept) begin
            q_push = 1'b0;
        end
    end

    // Parser state registers, updated only on an accepted octet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_IDLE;
            left_reg  <= '0;
            acc_reg   <= '0;
            arcs_reg  <= '0;
            vtag_reg  <= '0;
            first_reg <= 1'b1;
        end else if (accept) begin
            stage_reg <= stage_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            arcs_reg  <= arcs_next;
            vtag_reg  <= vtag_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

/* sv/srp_queue.sv */
// Short command queue between the parser and the result emitter.
// Depends on srp_pkg for the command type.
`default_nettype none

module srp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire srp_pkg::srp_cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output srp_pkg::srp_cmd_t    head_cmd,
    output logic                 empty
);
    import srp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    srp_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/srp_back.sv */
// Back part of the SNMP response parser: turns queued commands into result
// requests in an output register. Depends on srp_pkg.
`default_nettype none

module srp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srp_pkg::srp_cmd_t head_cmd,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [3:0]             m_field_kind,
    output logic [31:0]            m_field_value,
    output logic [7:0]             m_arc_index,
    output logic [7:0]             m_value_type,
    output logic                   m_last
);
    import srp_pkg::*;

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [3:0]  kind_reg;
    logic [31:0] value_reg;
    logic [7:0]  arc_reg;
    logic [7:0]  vtype_reg;
    logic        last_reg;

    logic        out_free, load;
    logic [7:0]  octet;
    logic [2:0]  quo;
    logic [7:0]  rem;

    // First OID octet split by 40 with a short compare ladder.
    assign octet = head_cmd.value[7:0];
    always_comb begin
        if (octet >= 8'd240) begin
            quo = 3'd6;
        end else if (octet >= 8'd200) begin
            quo = 3'd5;
        end else if (octet >= 8'd160) begin
            quo = 3'd4;
        end else if (octet >= 8'd120) begin
            quo = 3'd3;
        end else if (octet >= 8'd80) begin
            quo = 3'd2;
        end else if (octet >= 8'd40) begin
            quo = 3'd1;
        end else begin
            quo = 3'd0;
        end
        rem = octet - 8'({quo, 5'd0} + {2'd0, quo, 3'd0});
    end

    // A split command stays at the head until its second arc is loaded.
    assign out_free = !valid_reg || m_ready;
    assign load     = out_free && !q_empty;
    assign q_pop    = load && (!head_cmd.split || phase_reg);

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (out_free) begin
            valid_next = load;
        end
        if (load && head_cmd.split) begin
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= head_cmd.kind;
            vtype_reg <= head_cmd.vtype;
            last_reg  <= head_cmd.last;
            if (head_cmd.split) begin
                value_reg <= phase_reg ? {24'd0, rem} : {29'd0, quo};
                arc_reg   <= phase_reg ? 8'd1 : 8'd0;
            end else begin
                value_reg <= head_cmd.value;
                arc_reg   <= head_cmd.arc;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_field_kind  = kind_reg;
    assign m_field_value = value_reg;
    assign m_arc_index   = arc_reg;
    assign m_value_type  = vtype_reg;
    assign m_last        = last_reg;

endmodule

`default_nettype wire

/* sv/snmp_response_parser_unit.sv */
// SNMP v1 GetResponse parser: top level tying parser, queue and emitter.
// Depends on srp_pkg, srp_front, srp_queue and srp_back.
//
// The block takes one datagram octet per cycle on the s_ channel and returns
// decoded fields on the m_ channel: version, request id, error status, error
// index, each OID arc, then the value (an integer, one request per string
// octet, or the bare type tag), with m_last on the final one. A tag mismatch
// or a bad status/error-index length gives one failure request with m_last,
// and octets are ignored until the next octet with s_start_req set, which
// restarts parsing from any point. An octet is accepted every cycle while the
// command queue (QUEUE_DEPTH entries) has room; each result is registered in
// a queue slot, then in the output register. The first OID octet yields two
// arcs, loaded one after the other; every other octet yields at most one
// request, so the sustained rate is one octet per cycle when m_ready is high.
`default_nettype none

module snmp_response_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_start_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_field_kind,
    output logic [31:0]      m_field_value,
    output logic [7:0]       m_arc_index,
    output logic [7:0]       m_value_type,
    output logic             m_last
);
    import srp_pkg::*;

    srp_cmd_t push_cmd;
    srp_cmd_t head_cmd;
    logic     push, pop, full, empty;

    // Parser: classifies octets and produces commands.
    srp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_start_req (s_start_req),
        .q_full      (full),
        .q_push      (push),
        .q_cmd       (push_cmd)
    );

    // Queue decoupling the parser from output stalls.
    srp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    // Emitter: expands commands into result requests.
    srp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .q_empty       (empty),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_kind  (m_field_kind),
        .m_field_value (m_field_value),
        .m_arc_index   (m_arc_index),
        .m_value_type  (m_value_type),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

/* dv/snmp_response_parser_tb_pkg.sv */
// BER tag octets shared by the stimulus and the scoreboard of the SNMP
// response parser bench. No dependencies.
`timescale 1ns / 100ps

package snmp_response_parser_tb_pkg;

    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;
    localparam logic [7:0] TAG_NULL     = 8'h05;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_COUNTER  = 8'h41;
    localparam logic [7:0] TAG_GAUGE    = 8'h42;
    localparam logic [7:0] TAG_RESPONSE = 8'hA2;

endpackage

/* dv/snmp_response_parser_checker.sv */
// Scoreboard for the SNMP response parser: decodes every accepted octet on its
// own and compares the fields it expects with the result channel.
// Depends on srp_pkg and snmp_response_parser_tb_pkg.
`timescale 1ns / 100ps

module snmp_response_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_field_kind,
    input  logic [31:0] m_field_value,
    input  logic [7:0]  m_arc_index,
    input  logic [7:0]  m_value_type,
    input  logic        m_last,
    output int          mismatch_count,
    output int          fields_outstanding
);

    import srp_pkg::*;
    import snmp_response_parser_tb_pkg::*;

    localparam int unsigned FIRST_ARC_SPLIT = 40;

    typedef enum logic [4:0] {
        P_IDLE, P_MSG_TAG, P_MSG_LEN, P_VER_TAG, P_VER_LEN, P_VER_VAL,
        P_COM_TAG, P_COM_LEN, P_COM_SKIP, P_PDU_TAG, P_PDU_LEN,
        P_RID_TAG, P_RID_LEN, P_RID_VAL, P_STA_TAG, P_STA_LEN, P_STA_VAL,
        P_EIX_TAG, P_EIX_LEN, P_EIX_VAL, P_VBL_TAG, P_VBL_LEN, P_VB_TAG,
        P_VB_LEN, P_OID_TAG, P_OID_LEN, P_OID_FIRST, P_OID_ARC,
        P_VAL_TAG, P_VAL_LEN, P_VAL_INT, P_VAL_STR
    } parse_stage_e;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  arc;
        logic [7:0]  vtype;
        logic        last;
    } parsed_field_t;

    parsed_field_t expected_fields[$];
    parsed_field_t want;
    parsed_field_t got;
    int            mismatches;

    // Decoder state, mirroring the block's own registers.
    parse_stage_e  stage;
    logic [7:0]    octets_left;
    logic [31:0]   acc;
    logic [7:0]    arc_num;
    logic [7:0]    vtag;
    logic          first_octet;

    function automatic void clear_state();
        stage       = P_IDLE;
        octets_left = 8'd0;
        acc         = 32'd0;
        arc_num     = 8'd0;
        vtag        = 8'd0;
        first_octet = 1'b1;
    endfunction

    function automatic void note_field(input logic [3:0] kind, input logic [31:0] value,
                                       input logic [7:0] arc, input logic [7:0] vtype,
                                       input logic last);
        parsed_field_t f;
        f = {kind, value, arc, vtype, last};
        expected_fields.push_back(f);
    endfunction

    // A bad tag or length ends the datagram with a single failure field.
    function automatic void abort_datagram();
        stage = P_IDLE;
        note_field(KIND_FAIL, 32'd0, 8'd0, 8'd0, 1'b1);
    endfunction

    function automatic logic int_tag(input logic [7:0] b);
        return b == TAG_INTEGER || b == TAG_COUNTER || b == TAG_GAUGE;
    endfunction

    function automatic void int_start(input logic [7:0] len);
        octets_left = len;
        acc         = 32'd0;
        first_octet = 1'b1;
    endfunction

    // Shifts in one big-endian octet, sign-extending from the first one.
    function automatic logic int_take(input logic [7:0] b);
        if (first_octet && b[7]) begin
            acc = 32'hFFFF_FFFF;
        end
        first_octet = 1'b0;
        acc         = {acc[23:0], b};
        octets_left = octets_left - 8'd1;
        return octets_left == 8'd0;
    endfunction

    function automatic void decode_octet(input logic [7:0] b, input logic st);
        logic [3:0] int_kind;
        if (st) begin
            clear_state();
            stage = P_MSG_TAG;
        end
        int_kind = (vtag == TAG_INTEGER) ? KIND_SIGNED : KIND_UNSIGN;
        case (stage)
            P_MSG_TAG: if (b != TAG_SEQUENCE) abort_datagram(); else stage = P_MSG_LEN;
            P_MSG_LEN: stage = P_VER_TAG;
            P_VER_TAG: if (!int_tag(b)) abort_datagram(); else stage = P_VER_LEN;
            P_VER_LEN: begin
                int_start(b);
                if (b == 8'd0) begin
                    note_field(KIND_VERSION, 32'd0, 8'd0, 8'd0, 1'b0);
                    stage = P_COM_TAG;
                end else begin
                    stage = P_VER_VAL;
                end
            end
            P_VER_VAL: if (int_take(b)) begin
                note_field(KIND_VERSION, acc, 8'd0, 8'd0, 1'b0);
                stage = P_COM_TAG;
            end
            P_COM_TAG: if (b != TAG_OCTETS) abort_datagram(); else stage = P_COM_LEN;
            P_COM_LEN: begin
                octets_left = b;
                stage = (b == 8'd0) ? P_PDU_TAG : P_COM_SKIP;
            end
            P_COM_SKIP: begin
                octets_left = octets_left - 8'd1;
                if (octets_left == 8'd0) stage = P_PDU_TAG;
            end
            P_PDU_TAG: if (b != TAG_RESPONSE) abort_datagram(); else stage = P_PDU_LEN;
            P_PDU_LEN: stage = P_RID_TAG;
            P_RID_TAG: if (!int_tag(b)) abort_datagram(); else stage = P_RID_LEN;
            P_RID_LEN: begin
                int_start(b);
                if (b == 8'd0) begin
                    note_field(KIND_REQ_ID, 32'd0, 8'd0, 8'd0, 1'b0);
                    stage = P_STA_TAG;
                end else begin
                    stage = P_RID_VAL;
                end
            end
            P_RID_VAL: if (int_take(b)) begin
                note_field(KIND_REQ_ID, acc, 8'd0, 8'd0, 1'b0);
                stage = P_STA_TAG;
            end
            P_STA_TAG: if (b != TAG_INTEGER) abort_datagram(); else stage = P_STA_LEN;
            P_STA_LEN: if (b != 8'd1) abort_datagram(); else stage = P_STA_VAL;
            P_STA_VAL: begin
                note_field(KIND_STATUS, {24'd0, b}, 8'd0, 8'd0, 1'b0);
                stage = P_EIX_TAG;
            end
            P_EIX_TAG: if (b != TAG_INTEGER) abort_datagram(); else stage = P_EIX_LEN;
            P_EIX_LEN: if (b != 8'd1) abort_datagram(); else stage = P_EIX_VAL;
            P_EIX_VAL: begin
                note_field(KIND_ERR_IDX, {24'd0, b}, 8'd0, 8'd0, 1'b0);
                stage = P_VBL_TAG;
            end
            P_VBL_TAG: if (b != TAG_SEQUENCE) abort_datagram(); else stage = P_VBL_LEN;
            P_VBL_LEN: stage = P_VB_TAG;
            P_VB_TAG: if (b != TAG_SEQUENCE) abort_datagram(); else stage = P_VB_LEN;
            P_VB_LEN: stage = P_OID_TAG;
            P_OID_TAG: if (b != TAG_OID) abort_datagram(); else stage = P_OID_LEN;
            P_OID_LEN: begin
                octets_left = b;
                arc_num     = 8'd0;
                acc         = 32'd0;
                stage = (b == 8'd0) ? P_VAL_TAG : P_OID_FIRST;
            end
            // The first identifier octet packs the first two arcs.
            P_OID_FIRST: begin
                note_field(KIND_OID_ARC, 32'(b / FIRST_ARC_SPLIT), 8'd0, 8'd0, 1'b0);
                note_field(KIND_OID_ARC, 32'(b % FIRST_ARC_SPLIT), 8'd1, 8'd0, 1'b0);
                arc_num     = 8'd2;
                acc         = 32'd0;
                octets_left = octets_left - 8'd1;
                stage = (octets_left == 8'd0) ? P_VAL_TAG : P_OID_ARC;
            end
            // Base-128 groups; an arc also closes at the end of the identifier.
            P_OID_ARC: begin
                acc         = {acc[24:0], b[6:0]};
                octets_left = octets_left - 8'd1;
                if (!b[7] || octets_left == 8'd0) begin
                    note_field(KIND_OID_ARC, acc, arc_num, 8'd0, 1'b0);
                    arc_num = arc_num + 8'd1;
                    acc     = 32'd0;
                end
                if (octets_left == 8'd0) stage = P_VAL_TAG;
            end
            P_VAL_TAG: begin
                vtag = b;
                if (int_tag(b) || b == TAG_OCTETS) begin
                    stage = P_VAL_LEN;
                end else begin
                    note_field(KIND_BARE, 32'd0, 8'd0, b, 1'b1);
                    stage = P_IDLE;
                end
            end
            P_VAL_LEN: begin
                if (vtag == TAG_OCTETS) begin
                    octets_left = b;
                    if (b == 8'd0) begin
                        note_field(KIND_BARE, 32'd0, 8'd0, vtag, 1'b1);
                        stage = P_IDLE;
                    end else begin
                        stage = P_VAL_STR;
                    end
                end else begin
                    int_start(b);
                    if (b == 8'd0) begin
                        note_field(int_kind, 32'd0, 8'd0, vtag, 1'b1);
                        stage = P_IDLE;
                    end else begin
                        stage = P_VAL_INT;
                    end
                end
            end
            P_VAL_INT: if (int_take(b)) begin
                note_field(int_kind, acc, 8'd0, vtag, 1'b1);
                stage = P_IDLE;
            end
            P_VAL_STR: begin
                octets_left = octets_left - 8'd1;
                note_field(KIND_STR, {24'd0, b}, 8'd0, vtag, octets_left == 8'd0);
                if (octets_left == 8'd0) stage = P_IDLE;
            end
            default: ;
        endcase
    endfunction

    // Results are checked before the octet of the same edge is decoded; the
    // block registers every result in its queue and output register anyway.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_fields.delete();
            mismatches = 0;
            mismatch_count <= 0;
            fields_outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_field_kind, m_field_value, m_arc_index, m_value_type, m_last};
                if (expected_fields.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected field kind %0d value 0x%08h arc %0d type 0x%02h last %0d",
                             $time, got.kind, got.value, got.arc, got.vtype, got.last);
                end else begin
                    want = expected_fields.pop_front();
                    if (got != want) begin
                        mismatches++;
                        $display("%0t: expected kind %0d value 0x%08h arc %0d type 0x%02h last %0d",
                                 $time, want.kind, want.value, want.arc, want.vtype, want.last);
                        $display("%0t:      got kind %0d value 0x%08h arc %0d type 0x%02h last %0d",
                                 $time, got.kind, got.value, got.arc, got.vtype, got.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_octet(s_data_byte, s_start_req);
            end
            mismatch_count <= mismatches;
            fields_outstanding <= expected_fields.size();
        end
    end

endmodule

/* dv/snmp_response_parser_unit_tb.sv */
// Top of the SNMP response parser bench: clock, reset, datagram stimulus,
// result back-pressure and the verdict.
// Depends on snmp_response_parser_tb_pkg, the checker and the parser RTL.
`timescale 1ns / 100ps

module snmp_response_parser_unit_tb;

    import snmp_response_parser_tb_pkg::*;

    // Positions of the tag and length octets in the list of checked octets.
    localparam int SPOT_VER_TAG = 1;
    localparam int SPOT_STA_LEN = 6;
    localparam int SPOT_EIX_LEN = 8;
    localparam int SPOT_OID_TAG = 11;

    localparam int RANDOM_OCTETS = 300;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_start_req = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_field_kind;
    logic [31:0] m_field_value;
    logic [7:0]  m_arc_index;
    logic [7:0]  m_value_type;
    logic        m_last;

    int          mismatch_count;
    int          fields_outstanding;

    logic [7:0]  datagram[$];
    int          check_spots[$];
    int          oid_last;
    int          octets_sent = 0;
    int          src_mode = 0;
    int          stall_cycles = 0;

    snmp_response_parser_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_start_req   (s_start_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_kind  (m_field_kind),
        .m_field_value (m_field_value),
        .m_arc_index   (m_arc_index),
        .m_value_type  (m_value_type),
        .m_last        (m_last)
    );

    snmp_response_parser_checker field_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_req        (s_start_req),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_field_kind       (m_field_kind),
        .m_field_value      (m_field_value),
        .m_arc_index        (m_arc_index),
        .m_value_type       (m_value_type),
        .m_last             (m_last),
        .mismatch_count     (mismatch_count),
        .fields_outstanding (fields_outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Mode 0 never idles, mode 1 draws a random idle gap for every item, mode 2 idles now and then.
    function automatic int pick_gap(input int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 19);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r < 3) return $urandom_range(5, 8);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [7:0] pick_int_tag();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? TAG_INTEGER : (r == 1) ? TAG_COUNTER : TAG_GAUGE;
    endfunction

    task automatic add_random(input int n);
        repeat (n) datagram.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_tag(input logic [7:0] b);
        check_spots.push_back(datagram.size());
        datagram.push_back(b);
    endtask

    // Builds a well-formed GetResponse with random content into the datagram.
    task automatic build_response(input logic [7:0] ver_tag, input int ver_len,
                                  input int comm_len, input logic [7:0] rid_tag,
                                  input int rid_len, input int oid_len,
                                  input logic [7:0] val_tag, input int val_len);
        datagram.delete();
        check_spots.delete();
        add_tag(TAG_SEQUENCE);
        add_random(1);
        add_tag(ver_tag);
        datagram.push_back(8'(ver_len));
        add_random(ver_len);
        add_tag(TAG_OCTETS);
        datagram.push_back(8'(comm_len));
        add_random(comm_len);
        add_tag(TAG_RESPONSE);
        add_random(1);
        add_tag(rid_tag);
        datagram.push_back(8'(rid_len));
        add_random(rid_len);
        // Status and error index, then the binding list and the binding.
        repeat (2) begin
            add_tag(TAG_INTEGER);
            add_tag(8'd1);
            add_random(1);
        end
        repeat (2) begin
            add_tag(TAG_SEQUENCE);
            add_random(1);
        end
        add_tag(TAG_OID);
        datagram.push_back(8'(oid_len));
        // Mostly single-octet arcs, with some multi-octet groups.
        for (int i = 0; i < oid_len; i++) begin
            datagram.push_back({($urandom_range(0, 3) == 0), 7'($urandom_range(0, 127))});
        end
        oid_last = datagram.size() - 1;
        datagram.push_back(val_tag);
        if (val_tag == TAG_INTEGER || val_tag == TAG_COUNTER || val_tag == TAG_GAUGE ||
            val_tag == TAG_OCTETS) begin
            datagram.push_back(8'(val_len));
            add_random(val_len);
        end
    endtask

    // Offers one octet; valid stays up with the same payload until taken.
    task automatic push_octet(input logic [7:0] b, input logic st);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_start_req <= st;
        do @(posedge aclk); while (!s_ready);
        octets_sent++;
    endtask

    task automatic send_octets(input int count, input bit with_start);
        src_mode = $urandom_range(0, 2);
        for (int i = 0; i < count; i++) begin
            push_octet(datagram[i], with_start && i == 0);
        end
    endtask

    // Octets without a start request; the block ignores them when idle.
    task automatic send_noise(input int n);
        datagram.delete();
        add_random(n);
        send_octets(n, 1'b0);
    endtask

    // Result side: random stalls per request, plus two long hold-offs that
    // let the parser fill up and stall its input.
    initial begin
        int sink_mode;
        int taken;
        int hold;
        sink_mode = 0;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0) sink_mode = $urandom_range(0, 2);
            hold = pick_gap(sink_mode);
            if (taken == 40 || taken == 300) hold = LONG_HOLD;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int random_start;
        int shape;
        int spot;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Octets before any start request are ignored.
        send_noise(4);
        // Zero-length request id, empty identifier, zero-length signed value.
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 0, 0, TAG_INTEGER, 0);
        send_octets(datagram.size(), 1'b1);
        // Integers longer than four octets and an unsigned value.
        build_response(TAG_COUNTER, 6, 3, TAG_GAUGE, 4, 5, TAG_COUNTER, 5);
        send_octets(datagram.size(), 1'b1);
        // Single-octet identifier and an empty string value.
        build_response(TAG_GAUGE, 4, 1, TAG_INTEGER, 2, 1, TAG_OCTETS, 0);
        send_octets(datagram.size(), 1'b1);
        // String value, then octets after the finished datagram.
        build_response(TAG_INTEGER, 0, 2, TAG_COUNTER, 3, 4, TAG_OCTETS, 3);
        send_octets(datagram.size(), 1'b1);
        send_noise(3);
        // Bare value types and a zero-length unsigned value.
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 1, 3, TAG_NULL, 0);
        send_octets(datagram.size(), 1'b1);
        build_response(TAG_INTEGER, 1, 4, TAG_INTEGER, 1, 2, 8'hFF, 0);
        send_octets(datagram.size(), 1'b1);
        build_response(TAG_INTEGER, 2, 0, TAG_GAUGE, 1, 3, TAG_GAUGE, 0);
        send_octets(datagram.size(), 1'b1);
        // Identifier whose last octet still has its continuation bit set.
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 4, 6, TAG_INTEGER, 4);
        datagram[oid_last] = datagram[oid_last] | 8'h80;
        send_octets(datagram.size(), 1'b1);
        // Status and error index with lengths other than one.
        build_response(TAG_INTEGER, 1, 1, TAG_INTEGER, 1, 2, TAG_INTEGER, 1);
        datagram[check_spots[SPOT_STA_LEN]] = 8'd2;
        send_octets(datagram.size(), 1'b1);
        build_response(TAG_INTEGER, 1, 1, TAG_INTEGER, 1, 2, TAG_INTEGER, 1);
        datagram[check_spots[SPOT_EIX_LEN]] = 8'd0;
        send_octets(datagram.size(), 1'b1);
        // Wrong message tag on the start octet, wrong version and OID tags.
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 1, 2, TAG_INTEGER, 1);
        datagram[0] = 8'h31;
        send_octets(datagram.size(), 1'b1);
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 1, 2, TAG_INTEGER, 1);
        datagram[check_spots[SPOT_VER_TAG]] = TAG_OCTETS;
        send_octets(datagram.size(), 1'b1);
        build_response(TAG_INTEGER, 1, 0, TAG_INTEGER, 1, 2, TAG_INTEGER, 1);
        datagram[check_spots[SPOT_OID_TAG]] = TAG_SEQUENCE;
        send_octets(datagram.size(), 1'b1);
        // A new start in the middle of a datagram restarts parsing.
        build_response(TAG_INTEGER, 1, 2, TAG_INTEGER, 2, 3, TAG_INTEGER, 2);
        send_octets(12, 1'b1);
        build_response(TAG_INTEGER, 1, 2, TAG_INTEGER, 2, 3, TAG_INTEGER, 2);
        send_octets(datagram.size(), 1'b1);
        // Longest identifier and longest string value.
        build_response(TAG_INTEGER, 1, 255, TAG_INTEGER, 1, 255, TAG_OCTETS, 255);
        send_octets(datagram.size(), 1'b1);

        // Random datagrams: mostly well-formed, some corrupted or cut short.
        random_start = octets_sent;
        while (octets_sent - random_start < RANDOM_OCTETS) begin
            int comm_len;
            int oid_len;
            int val_len;
            int r;
            logic [7:0] val_tag;
            r = $urandom_range(0, 99);
            comm_len = (r < 60) ? $urandom_range(0, 8) :
                       (r < 98) ? $urandom_range(9, 40) : $urandom_range(100, 255);
            r = $urandom_range(0, 99);
            oid_len = (r < 5) ? 0 : (r < 97) ? $urandom_range(1, 14) : $urandom_range(30, 255);
            r = $urandom_range(0, 19);
            val_tag = (r < 6) ? TAG_INTEGER : (r < 9) ? TAG_COUNTER : (r < 12) ? TAG_GAUGE :
                      (r < 17) ? TAG_OCTETS : 8'($urandom_range(0, 255));
            if (val_tag == TAG_OCTETS) begin
                val_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            end else begin
                val_len = pick_len();
            end
            build_response(pick_int_tag(), pick_len(), comm_len, pick_int_tag(), pick_len(),
                           oid_len, val_tag, val_len);
            shape = $urandom_range(0, 9);
            case (shape)
                0: begin
                    spot = check_spots[$urandom_range(0, check_spots.size() - 1)];
                    datagram[spot] = datagram[spot] ^ 8'($urandom_range(1, 255));
                    send_octets(datagram.size(), 1'b1);
                end
                1: begin
                    datagram[$urandom_range(1, datagram.size() - 1)] = 8'($urandom_range(0, 255));
                    send_octets(datagram.size(), 1'b1);
                end
                2: send_octets($urandom_range(1, datagram.size() - 1), 1'b1);
                3: begin
                    send_octets(datagram.size(), 1'b1);
                    send_noise($urandom_range(1, 4));
                end
                default: send_octets(datagram.size(), 1'b1);
            endcase
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected field, then a few more cycles.
        @(posedge aclk);
        while (fields_outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && fields_outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/srp_pkg.sv
sv/srp_front.sv
sv/srp_queue.sv
sv/srp_back.sv
sv/snmp_response_parser_unit.sv
dv/snmp_response_parser_tb_pkg.sv
dv/snmp_response_parser_checker.sv
dv/snmp_response_parser_unit_tb.sv
